FILE: rtl/nmea_pkg.sv
// ----------------------------------------------------------------------------
// nmea_pkg
// Shared types, character codes and parse phase codes of the GGA parser.
// ----------------------------------------------------------------------------
package nmea_pkg;

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_STAR   = 8'h2A;
	localparam logic [7:0] CHAR_COMMA  = 8'h2C;
	localparam logic [7:0] CHAR_G      = 8'h47;
	localparam logic [7:0] CHAR_A      = 8'h41;

	localparam logic [7:0] MAX_LINE_RESET = 8'd90;
	localparam int         QUEUE_DEPTH_DEF = 2;

	localparam logic [2:0] PH_FIRST_COMMA = 3'd0;
	localparam logic [2:0] PH_TIME        = 3'd1;
	localparam logic [2:0] PH_SKIP        = 3'd2;
	localparam logic [2:0] PH_POS         = 3'd3;
	localparam logic [2:0] PH_DONE        = 3'd4;

	localparam logic [1:0] FIX_NO_TIME = 2'd0;
	localparam logic [1:0] FIX_NO_POS  = 2'd1;
	localparam logic [1:0] FIX_FULL    = 2'd2;

	localparam logic [2:0] HDR_TYPE_FIRST = 3'd3;
	localparam logic [2:0] HDR_DONE       = 3'd6;

	localparam logic [4:0] TIME_LAST  = 5'd5;
	localparam logic [4:0] TIME_LEN   = 5'd6;
	localparam logic [4:0] LAT_LEN    = 5'd8;
	localparam logic [4:0] LAT_HEMI   = 5'd9;
	localparam logic [4:0] LON_FIRST  = 5'd11;
	localparam logic [4:0] LON_END    = 5'd19;
	localparam logic [4:0] LON_HEMI   = 5'd20;

	// classified byte handed from front to back
	typedef struct packed {
		logic       start;  // '$': clear capture
		logic       last;   // byte that closes the sentence
		logic       gga;    // header matched, emit on last
		logic [7:0] data;
	} token_t;

	// expected header letter at sentence position 3..5
	function automatic logic [7:0] hdr_expect(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd3:    r = CHAR_G;
			3'd4:    r = CHAR_G;
			default: r = CHAR_A;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/nmea_if.sv
// ----------------------------------------------------------------------------
// nmea_if
// Valid/ready channels: received bytes in, GGA fix records out.
// ----------------------------------------------------------------------------
interface nmea_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nmea_fix_if;
	logic        valid;
	logic        ready;
	logic [1:0]  fix_status;
	logic [47:0] time_chars;
	logic [63:0] latitude_chars;
	logic [7:0]  latitude_hemisphere;
	logic [63:0] longitude_chars;
	logic [7:0]  longitude_hemisphere;

	modport source (output valid, output fix_status, output time_chars,
		output latitude_chars, output latitude_hemisphere,
		output longitude_chars, output longitude_hemisphere, input ready);
	modport sink (input valid, input fix_status, input time_chars,
		input latitude_chars, input latitude_hemisphere,
		input longitude_chars, input longitude_hemisphere, output ready);
endinterface

FILE: rtl/nmea_front.sv
// ----------------------------------------------------------------------------
// nmea_front
// Sentence framing: start, length limit, header check and star tail.
// Emits one token per byte that belongs to a live sentence.
// ----------------------------------------------------------------------------
module nmea_front (
	input  logic                 clk,
	input  logic                 arst_n,
	nmea_rx_if.sink              rx,
	input  logic [7:0]           max_line_bytes,
	input  logic                 full,
	output logic                 push,
	output nmea_pkg::token_t     tok
);
	import nmea_pkg::*;

	logic       in_q;
	logic [7:0] cnt_q;
	logic       star_q;
	logic [1:0] tail_q;
	logic [2:0] hdr_q;
	logic       match_q;

	logic       in_d;
	logic [7:0] cnt_d;
	logic       star_d;
	logic [1:0] tail_d;
	logic [2:0] hdr_d;
	logic       match_d;
	logic       accept;
	logic       is_start;
	logic       ended;
	logic [7:0] c;

	assign rx.ready = !full;
	assign accept   = rx.valid && rx.ready;
	assign c        = rx.rx_byte;
	assign is_start = (c == CHAR_DOLLAR);

	always_comb begin
		in_d    = in_q;
		cnt_d   = cnt_q;
		star_d  = star_q;
		tail_d  = tail_q;
		hdr_d   = hdr_q;
		match_d = match_q;
		ended   = 1'b0;
		if (is_start) begin
			cnt_d   = 8'd1;
			star_d  = 1'b0;
			tail_d  = 2'd0;
			hdr_d   = 3'd1;
			match_d = 1'b1;
			in_d    = (8'd1 < max_line_bytes);
		end else if (in_q) begin
			if (hdr_q < HDR_DONE) begin
				if (hdr_q >= HDR_TYPE_FIRST && c != hdr_expect(hdr_q))
					match_d = 1'b0;
				hdr_d = hdr_q + 3'd1;
			end
			if (c == CHAR_STAR) begin
				star_d = 1'b1;
				tail_d = 2'd0;
			end else if (star_q) begin
				tail_d = tail_q + 2'd1;
				ended  = (tail_d == 2'd2);
			end
			if (ended) begin
				in_d = 1'b0;
			end else begin
				cnt_d = cnt_q + 8'd1;
				if (cnt_d >= max_line_bytes)
					in_d = 1'b0;
			end
		end
	end

	assign push       = accept && (is_start || in_q);
	assign tok.start  = is_start;
	assign tok.last   = ended;
	assign tok.gga    = match_d && (hdr_d >= HDR_DONE);
	assign tok.data   = c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_q    <= 1'b0;
			cnt_q   <= '0;
			star_q  <= 1'b0;
			tail_q  <= '0;
			hdr_q   <= '0;
			match_q <= 1'b0;
		end else if (accept) begin
			in_q    <= in_d;
			cnt_q   <= cnt_d;
			star_q  <= star_d;
			tail_q  <= tail_d;
			hdr_q   <= hdr_d;
			match_q <= match_d;
		end
	end

endmodule

FILE: rtl/nmea_queue.sv
// ----------------------------------------------------------------------------
// nmea_queue
// Small token FIFO between framing and field capture.
// ----------------------------------------------------------------------------
module nmea_queue #(
	parameter int DEPTH = nmea_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  nmea_pkg::token_t     push_tok,
	output logic                 full,
	input  logic                 pop,
	output logic                 tok_valid,
	output nmea_pkg::token_t     tok
);
	import nmea_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);

	token_t        mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (cnt_q == DEPTH_C);
	assign tok_valid = (cnt_q != '0);
	assign tok       = mem_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && tok_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == LAST_P) ? '0 : wr_q + PW'(1);
			if (do_pop)
				rd_q <= (rd_q == LAST_P) ? '0 : rd_q + PW'(1);
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/nmea_back.sv
// ----------------------------------------------------------------------------
// nmea_back
// Field capture from comma positions and the fix record output register.
// ----------------------------------------------------------------------------
module nmea_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tok_valid,
	input  nmea_pkg::token_t     tok,
	output logic                 pop,
	nmea_fix_if.source           fix
);
	import nmea_pkg::*;

	logic [2:0]      ph_q, ph_d;
	logic [4:0]      off_q, off_d;
	logic            te_q, te_d;
	logic            pe_q, pe_d;
	logic [5:0][7:0] time_q, time_d;
	logic [7:0][7:0] lat_q, lat_d;
	logic [7:0]      lath_q, lath_d;
	logic [7:0][7:0] lon_q, lon_d;
	logic [7:0]      lonh_q, lonh_d;
	logic            out_v_q;
	logic [2:0]      t_idx, la_idx, lo_idx;
	logic [4:0]      lo_diff;
	logic            emit;
	logic [7:0]      c;

	assign c       = tok.data;
	assign pop     = tok_valid && (!out_v_q || fix.ready);
	assign emit    = pop && !tok.start && tok.last && tok.gga;
	assign t_idx   = 3'd5 - off_q[2:0];
	assign la_idx  = 3'd7 - off_q[2:0];
	assign lo_diff = 5'd18 - off_q;
	assign lo_idx  = lo_diff[2:0];

	always_comb begin
		ph_d   = ph_q;
		off_d  = off_q;
		te_d   = te_q;
		pe_d   = pe_q;
		time_d = time_q;
		lat_d  = lat_q;
		lath_d = lath_q;
		lon_d  = lon_q;
		lonh_d = lonh_q;
		if (tok.start) begin
			ph_d   = PH_FIRST_COMMA;
			off_d  = '0;
			te_d   = 1'b1;
			pe_d   = 1'b1;
			time_d = '0;
			lat_d  = '0;
			lath_d = '0;
			lon_d  = '0;
			lonh_d = '0;
		end else begin
			unique case (ph_q)
				PH_FIRST_COMMA: begin
					if (c == CHAR_COMMA) begin
						ph_d  = PH_TIME;
						off_d = '0;
					end
				end
				PH_TIME: begin
					if (off_q == '0 && c == CHAR_COMMA) begin
						ph_d = PH_DONE;
					end else begin
						te_d = 1'b0;
						if (off_q < TIME_LEN)
							time_d[t_idx] = c;
						if (off_q >= TIME_LAST) begin
							ph_d  = PH_SKIP;
							off_d = '0;
						end else begin
							off_d = off_q + 5'd1;
						end
					end
				end
				PH_SKIP: begin
					if (c == CHAR_COMMA) begin
						ph_d  = PH_POS;
						off_d = '0;
					end
				end
				PH_POS: begin
					if (off_q == '0 && c == CHAR_COMMA) begin
						ph_d = PH_DONE;
					end else begin
						pe_d = 1'b0;
						if (off_q < LAT_LEN)
							lat_d[la_idx] = c;
						else if (off_q == LAT_HEMI)
							lath_d = c;
						else if (off_q >= LON_FIRST && off_q < LON_END)
							lon_d[lo_idx] = c;
						else if (off_q == LON_HEMI)
							lonh_d = c;
						if (off_q >= LON_HEMI)
							ph_d = PH_DONE;
						else
							off_d = off_q + 5'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_FIRST_COMMA;
			off_q  <= '0;
			te_q   <= 1'b0;
			pe_q   <= 1'b0;
			time_q <= '0;
			lat_q  <= '0;
			lath_q <= '0;
			lon_q  <= '0;
			lonh_q <= '0;
		end else if (pop) begin
			ph_q   <= ph_d;
			off_q  <= off_d;
			te_q   <= te_d;
			pe_q   <= pe_d;
			time_q <= time_d;
			lat_q  <= lat_d;
			lath_q <= lath_d;
			lon_q  <= lon_d;
			lonh_q <= lonh_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (emit)
			out_v_q <= 1'b1;
		else if (fix.ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			fix.fix_status           <= te_d ? FIX_NO_TIME : (pe_d ? FIX_NO_POS : FIX_FULL);
			fix.time_chars           <= time_d;
			fix.latitude_chars       <= lat_d;
			fix.latitude_hemisphere  <= lath_d;
			fix.longitude_chars      <= lon_d;
			fix.longitude_hemisphere <= lonh_d;
		end
	end

	assign fix.valid = out_v_q;

endmodule

FILE: rtl/nmea_gga_sentence_parser.sv
// ----------------------------------------------------------------------------
// nmea_gga_sentence_parser
// NMEA 0183 GGA sentence parser: serial bytes in, one fix record per GGA.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  rx       in   valid/ready    rx_byte
//  fix      out  valid/ready    fix_status, time/lat/lon chars, hemispheres
//  apb      in   psel/penable   max_line_bytes at address 0
//
//  One byte per cycle sustained while the fix output does not stall. The
//  closing byte's token passes through the token queue and then the fix
//  output register before the record is valid. A stalled fix output backs
//  up the token queue, then rx.ready drops. No clearing pass after reset.
// ----------------------------------------------------------------------------
module nmea_gga_sentence_parser #(
	parameter int QUEUE_DEPTH = nmea_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	nmea_rx_if.sink     rx,
	nmea_fix_if.source  fix,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import nmea_pkg::*;

	logic [7:0] max_line_q;
	logic       full;
	logic       push;
	logic       pop;
	logic       tok_valid;
	token_t     push_tok;
	token_t     tok;
	logic       reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == 1'b0);
	assign prdata  = reg_hit ? {24'd0, max_line_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_line_q <= MAX_LINE_RESET;
		else if (psel && penable && pwrite && pready && reg_hit)
			max_line_q <= pwdata[7:0];
	end

	nmea_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx             (rx),
		.max_line_bytes (max_line_q),
		.full           (full),
		.push           (push),
		.tok            (push_tok)
	);

	nmea_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_tok  (push_tok),
		.full      (full),
		.pop       (pop),
		.tok_valid (tok_valid),
		.tok       (tok)
	);

	nmea_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok       (tok),
		.pop       (pop),
		.fix       (fix)
	);

endmodule

FILE: test/nmea_gga_sentence_parser_tb.sv
// ----------------------------------------------------------------------------
// nmea_gga_sentence_parser_tb
// Drives serial bytes into the GGA parser and checks every fix record against
// a byte-level predictor. The stimulus starts with directed sentences, then
// sends random sentences, mostly well formed, under several line limits.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module nmea_gga_sentence_parser_tb;
	import nmea_pkg::*;

	localparam logic [2:0] REG_MAX_LINE_ADDR = 3'd0;
	localparam int IDLE_PCT    = 21;
	localparam int DRAIN_WAIT  = 8;
	localparam int ROUND_BYTES = 150;
	localparam int BYTE_GOAL   = 1550;
	localparam int MAX_ROUNDS  = 60;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [1:0]  status;
		logic [47:0] time_chars;
		logic [63:0] lat_chars;
		logic [7:0]  lat_hemi;
		logic [63:0] lon_chars;
		logic [7:0]  lon_hemi;
	} fix_rec_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	nmea_rx_if  rx_ch ();
	nmea_fix_if fix_ch ();

	nmea_gga_sentence_parser DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.fix     (fix_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	logic [7:0] rx_backlog[$];
	fix_rec_t   fixes_due[$];
	int         bytes_queued = 0;
	int         bad_count    = 0;
	int         cycles       = 0;
	logic       steady       = 1'b0;

	// predictor state
	logic [7:0]  line_limit;
	logic        in_frame;
	int          byte_cnt;
	logic        star_hit;
	int          tail_cnt;
	int          hdr_pos;
	logic        is_gga;
	logic [2:0]  phase;
	int          offs;
	logic        no_time;
	logic        no_pos;
	logic [47:0] time_acc;
	logic [63:0] lat_acc;
	logic [7:0]  lat_hemi;
	logic [63:0] lon_acc;
	logic [7:0]  lon_hemi;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic predict_fix(input logic [7:0] c);
		fix_rec_t rec;
		logic     done;
		done = 1'b0;
		if (c == CHAR_DOLLAR) begin
			in_frame = 1'b1;
			byte_cnt = 1;
			star_hit = 1'b0;
			tail_cnt = 0;
			hdr_pos  = 1;
			is_gga   = 1'b1;
			phase    = PH_FIRST_COMMA;
			offs     = 0;
			no_time  = 1'b1;
			no_pos   = 1'b1;
			time_acc = '0;
			lat_acc  = '0;
			lat_hemi = '0;
			lon_acc  = '0;
			lon_hemi = '0;
			if (byte_cnt >= line_limit)
				in_frame = 1'b0;
			return;
		end
		if (!in_frame)
			return;

		if (hdr_pos < HDR_DONE) begin
			if (hdr_pos >= HDR_TYPE_FIRST &&
				c != ((hdr_pos == HDR_DONE - 1) ? CHAR_A : CHAR_G))
				is_gga = 1'b0;
			hdr_pos++;
		end

		case (phase)
			PH_FIRST_COMMA: begin
				if (c == CHAR_COMMA) begin
					phase = PH_TIME;
					offs  = 0;
				end
			end
			PH_TIME: begin
				if (offs == 0 && c == CHAR_COMMA) begin
					phase = PH_DONE;
				end else begin
					no_time = 1'b0;
					if (offs < TIME_LEN)
						time_acc[8 * (TIME_LAST - offs) +: 8] = c;
					if (offs >= TIME_LAST) begin
						phase = PH_SKIP;
						offs  = 0;
					end else begin
						offs++;
					end
				end
			end
			PH_SKIP: begin
				if (c == CHAR_COMMA) begin
					phase = PH_POS;
					offs  = 0;
				end
			end
			PH_POS: begin
				if (offs == 0 && c == CHAR_COMMA) begin
					phase = PH_DONE;
				end else begin
					no_pos = 1'b0;
					if (offs < LAT_LEN)
						lat_acc[8 * (LAT_LEN - 1 - offs) +: 8] = c;
					else if (offs == LAT_HEMI)
						lat_hemi = c;
					else if (offs >= LON_FIRST && offs < LON_END)
						lon_acc[8 * (LON_END - 1 - offs) +: 8] = c;
					else if (offs == LON_HEMI)
						lon_hemi = c;
					if (offs >= LON_HEMI)
						phase = PH_DONE;
					else
						offs++;
				end
			end
			default: ;
		endcase

		if (c == CHAR_STAR) begin
			star_hit = 1'b1;
			tail_cnt = 0;
		end else if (star_hit) begin
			tail_cnt++;
			if (tail_cnt == 2)
				done = 1'b1;
		end

		if (done) begin
			in_frame = 1'b0;
			if (is_gga && hdr_pos >= HDR_DONE) begin
				rec.status     = no_time ? FIX_NO_TIME : (no_pos ? FIX_NO_POS : FIX_FULL);
				rec.time_chars = time_acc;
				rec.lat_chars  = lat_acc;
				rec.lat_hemi   = lat_hemi;
				rec.lon_chars  = lon_acc;
				rec.lon_hemi   = lon_hemi;
				fixes_due.push_back(rec);
			end
		end else begin
			byte_cnt++;
			if (byte_cnt >= line_limit)
				in_frame = 1'b0;
		end
	endtask

	// byte driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_ch.valid && rx_ch.ready)
				predict_fix(rx_ch.rx_byte);
			if (!rx_ch.valid || rx_ch.ready) begin
				if (rx_backlog.size() != 0 &&
					(steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
					rx_ch.valid   <= 1'b1;
					rx_ch.rx_byte <= rx_backlog.pop_front();
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			bad_count++;
		end
	endtask

	// fix monitor
	always @(posedge clk) begin
		fix_rec_t rec;
		if (arst_n) begin
			if (fix_ch.valid && fix_ch.ready) begin
				if (fixes_due.size() == 0) begin
					$display("%0t: unexpected fix, expected none got status %h",
						$time, fix_ch.fix_status);
					bad_count++;
				end else begin
					rec = fixes_due.pop_front();
					check_field("fix_status", rec.status, fix_ch.fix_status);
					check_field("time_chars", rec.time_chars, fix_ch.time_chars);
					check_field("latitude_chars", rec.lat_chars, fix_ch.latitude_chars);
					check_field("latitude_hemisphere", rec.lat_hemi,
						fix_ch.latitude_hemisphere);
					check_field("longitude_chars", rec.lon_chars, fix_ch.longitude_chars);
					check_field("longitude_hemisphere", rec.lon_hemi,
						fix_ch.longitude_hemisphere);
				end
			end
			fix_ch.ready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		rx_backlog.push_back(b);
		bytes_queued++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	function automatic logic [7:0] upper();
		return 8'(8'h41 + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] hex_char();
		int v;
		v = $urandom_range(0, 15);
		return (v < 10) ? 8'(8'h30 + v) : 8'(8'h37 + v);
	endfunction

	// mostly digits and dots, sometimes any byte that does not frame
	function automatic logic [7:0] field_char();
		logic [7:0] b;
		if ($urandom_range(0, 9) < 8)
			return ($urandom_range(0, 10) == 10) ? 8'h2E : 8'(8'h30 + $urandom_range(0, 9));
		b = 8'($urandom_range(0, 255));
		while (b == CHAR_DOLLAR || b == CHAR_COMMA || b == CHAR_STAR)
			b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	task automatic push_field(input int len);
		repeat (len) push_byte(field_char());
	endtask

	task automatic queue_sentence();
		int kind;
		logic tidy;
		kind = $urandom_range(0, 99);
		tidy = ($urandom_range(0, 99) < 70);
		if (kind < 8) begin
			repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
			return;
		end
		if (kind < 14)
			push_text("$GPG");
		push_byte(CHAR_DOLLAR);
		if (kind < 20) begin
			push_byte(upper());
			push_byte(upper());
		end else begin
			push_text("GP");
		end
		if (kind < 86) begin
			push_text("GGA");
		end else if (kind < 93) begin
			push_byte(CHAR_G);
			push_byte(upper());
			push_byte(CHAR_A);
		end else begin
			push_byte(upper());
			push_byte(upper());
			push_byte(upper());
		end
		push_byte(CHAR_COMMA);
		if (tidy) begin
			if ($urandom_range(0, 19) != 0)
				push_field($urandom_range(0, 1) ? 6 : 9);
			push_byte(CHAR_COMMA);
			if ($urandom_range(0, 19) != 0)
				push_field(8);
			push_byte(CHAR_COMMA);
			push_byte($urandom_range(0, 1) ? "N" : "S");
			push_byte(CHAR_COMMA);
			push_field(8);
			push_byte(CHAR_COMMA);
			push_byte($urandom_range(0, 1) ? "E" : "W");
		end else begin
			push_field($urandom_range(0, 10));
			push_byte(CHAR_COMMA);
			push_field($urandom_range(0, 11));
			push_byte(CHAR_COMMA);
			push_field($urandom_range(0, 2));
			push_byte(CHAR_COMMA);
			push_field($urandom_range(0, 11));
			push_byte(CHAR_COMMA);
			push_field($urandom_range(0, 2));
		end
		repeat ($urandom_range(0, 5)) begin
			push_byte(CHAR_COMMA);
			push_field($urandom_range(0, 4));
		end
		if (kind == 99)
			push_field($urandom_range(200, 260));
		if (kind % 17 == 0)
			return;
		push_byte(CHAR_STAR);
		if (kind % 13 == 0) begin
			push_byte(hex_char());
			push_byte(CHAR_STAR);
		end
		push_byte(hex_char());
		push_byte(hex_char());
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (rx_backlog.size() != 0 || rx_ch.valid || fixes_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_line_limit(input logic [7:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_MAX_LINE_ADDR;
		pwdata  <= {24'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		line_limit = v;
		@(negedge clk);
	endtask

	initial begin
		int         round;
		int         mark;
		logic [7:0] limit;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		fix_ch.ready  = 1'b0;
		line_limit    = MAX_LINE_RESET;
		in_frame      = 1'b0;
		byte_cnt      = 0;
		star_hit      = 1'b0;
		tail_cnt      = 0;
		hdr_pos       = 0;
		is_gga        = 1'b0;
		phase         = PH_FIRST_COMMA;
		offs          = 0;
		no_time       = 1'b0;
		no_pos        = 1'b0;
		time_acc      = '0;
		lat_acc       = '0;
		lat_hemi      = '0;
		lon_acc       = '0;
		lon_hemi      = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// bytes and stars outside a sentence are ignored
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(CHAR_STAR);
		push_text("$GPGGA,,*4A");
		push_text("$GPGGA,123519,,*00");
		push_text("$GPGGA,123519,4807.038,N,01131.00,E,1*47");
		// extreme byte values inside captured fields
		push_text("$GPGGA,");
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(8'h80);
		push_text("7F4,");
		push_byte(8'h7F);
		push_text("000000.,");
		push_byte(8'hFF);
		push_text(",");
		repeat (8) push_byte(8'hFF);
		push_text(",W*00");
		push_text("$GP$GPGGA,1*12");
		push_text("$GPGLL,1,2*00");
		push_text("$GG*AB");
		push_text("$GPGGA,12*3*45");
		push_text("$GPGGA*00");
		wait_drained();

		// limit reached on the closing byte, and a dropped sentence
		write_line_limit(8'd9);
		push_text("$GPGGA*1X");
		push_text("$GPGGA,12*34");
		wait_drained();

		// dropped right after the dollar
		write_line_limit(8'd1);
		push_text("$GPGGA*12$GPGGA,,*00");
		wait_drained();

		write_line_limit(8'd255);
		for (round = 0; round < MAX_ROUNDS && bytes_queued < BYTE_GOAL; round++) begin
			if (round > 0) begin
				case (round)
					1: limit = 8'd8;
					2: limit = MAX_LINE_RESET;
					default: begin
						case ($urandom_range(0, 5))
							0:       limit = 8'd8;
							1:       limit = 8'd255;
							2:       limit = 8'($urandom_range(9, 59));
							default: limit = 8'($urandom_range(60, 254));
						endcase
					end
				endcase
				write_line_limit(limit);
			end
			steady = (round == 2);
			mark = bytes_queued;
			while (bytes_queued - mark < ROUND_BYTES)
				queue_sentence();
			wait_drained();
		end
		steady = 1'b0;

		if (bad_count == 0 && fixes_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: sim.f
rtl/nmea_pkg.sv
rtl/nmea_if.sv
rtl/nmea_front.sv
rtl/nmea_queue.sv
rtl/nmea_back.sv
rtl/nmea_gga_sentence_parser.sv
test/nmea_gga_sentence_parser_tb.sv
